// ----- rtl/atrp_pkg.sv -----
`default_nettype none
package atrp_pkg;

	// longest line is LINE_LIMIT bytes (a prompt at full length)
	localparam int LINE_LIMIT = 256;
	localparam int CNT_W = $clog2(LINE_LIMIT + 1);
	localparam int LEN_W = 9;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_RAW  = 2'd3;

	localparam logic [2:0] EV_RAW     = 3'd0;
	localparam logic [2:0] EV_LINE    = 3'd1;
	localparam logic [2:0] EV_OK      = 3'd2;
	localparam logic [2:0] EV_ERROR   = 3'd3;
	localparam logic [2:0] EV_TIMEOUT = 3'd4;
	localparam logic [2:0] EV_ACCEPT  = 3'd5;
	localparam logic [2:0] EV_REJECT  = 3'd6;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_O   = 8'h4F;
	localparam logic [7:0] CH_K   = 8'h4B;
	localparam logic [7:0] CH_E   = 8'h45;
	localparam logic [7:0] CH_R   = 8'h52;
	localparam logic [7:0] CH_F   = 8'h46;
	localparam logic [7:0] CH_A   = 8'h41;
	localparam logic [7:0] CH_I   = 8'h49;
	localparam logic [7:0] CH_L   = 8'h4C;

	localparam logic [2:0] ERR_LEN  = 3'd5;
	localparam logic [2:0] FAIL_LEN = 3'd4;

	localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd1000;

	typedef struct packed {
		logic [1:0] ok_prog;
		logic [2:0] err_prog;
		logic [2:0] fail_prog;
		logic [1:0] found;
		logic       zero_seen;
	} atrp_match_t;

	localparam atrp_match_t MATCH_CLEAR = '0;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  rx_byte;
		logic [31:0] timeout_ms;
		logic [31:0] raw_length;
	} atrp_req_t;

	typedef struct packed {
		logic [2:0]       event_res;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] line_length;
		logic             last;
	} atrp_res_t;

	// up to two results pushed per item
	typedef struct packed {
		logic [1:0] n;
		atrp_res_t  r0;
		atrp_res_t  r1;
	} atrp_push_t;

	function automatic logic [7:0] err_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = CH_E;
			3'd1:    c = CH_R;
			3'd2:    c = CH_R;
			3'd3:    c = CH_O;
			3'd4:    c = CH_R;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] fail_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = CH_F;
			3'd1:    c = CH_A;
			3'd2:    c = CH_I;
			3'd3:    c = CH_L;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/atrp_if.sv -----
`default_nettype none
interface atrp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  rx_byte;
	logic [31:0] timeout_ms;
	logic [31:0] raw_length;

	modport source (output valid, kind, rx_byte, timeout_ms, raw_length, input ready);
	modport sink   (input valid, kind, rx_byte, timeout_ms, raw_length, output ready);
endinterface

interface atrp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] data_byte;
	logic [8:0] line_length;
	logic       last;

	modport source (output valid, event_res, data_byte, line_length, last, input ready);
	modport sink   (input valid, event_res, data_byte, line_length, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/at_response_line_parser.sv -----
// path: a result item passes the input register and the result queue before it is offered
// throughput: one input item per cycle while the result queue has room for two; an item
//   with two results offers them in turn from the four-entry result queue
// reset: arst_n clears all line, match, timer and raw state and the queue at once;
//   default timeout returns to 1000 ms
`default_nettype none
module at_response_line_parser import atrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	atrp_in_if.sink     req,
	atrp_out_if.source  rsp
);

	// input register stage: one item parked ahead of the parser core
	logic       vld_s1;
	atrp_req_t  req_s1;

	// queue has room for the worst case of two results from one item
	logic       room;
	logic       fire;
	atrp_push_t push;

	// the core fires whenever an item is parked and the queue can take both results
	assign fire      = vld_s1 && room;
	// ready does not depend on the output side directly, only on the parked item and queue fill
	assign req.ready = !vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.kind       <= req.kind;
			req_s1.rx_byte    <= req.rx_byte;
			req_s1.timeout_ms <= req.timeout_ms;
			req_s1.raw_length <= req.raw_length;
		end
	end

	// line splitter, pattern matchers, timeout counter and raw byte counter
	atrp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.req         (req_s1),
		.push        (push)
	);

	// result queue parts the core from the output handshake
	atrp_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

// ----- rtl/atrp_matcher.sv -----
`default_nettype none
module atrp_matcher import atrp_pkg::*; (
	input  atrp_match_t cur,
	input  logic [7:0]  rx_byte,
	output atrp_match_t nxt
);

	always_comb begin
		nxt = cur;
		if (!cur.zero_seen) begin
			if (rx_byte == CH_NUL) begin
				nxt.zero_seen = 1'b1;
			end else begin
				// OK
				if (cur.ok_prog == 2'd1 && rx_byte == CH_K) begin
					nxt.found[0] = 1'b1;
					nxt.ok_prog  = 2'd0;
				end else begin
					nxt.ok_prog = (rx_byte == CH_O) ? 2'd1 : 2'd0;
				end
				// ERROR
				if (cur.err_prog < ERR_LEN && rx_byte == err_char(cur.err_prog)) begin
					if (cur.err_prog + 3'd1 == ERR_LEN) begin
						nxt.found[1] = 1'b1;
						nxt.err_prog = 3'd0;
					end else begin
						nxt.err_prog = cur.err_prog + 3'd1;
					end
				end else begin
					nxt.err_prog = (rx_byte == CH_E) ? 3'd1 : 3'd0;
				end
				// FAIL
				if (cur.fail_prog < FAIL_LEN && rx_byte == fail_char(cur.fail_prog)) begin
					if (cur.fail_prog + 3'd1 == FAIL_LEN) begin
						nxt.found[1]  = 1'b1;
						nxt.fail_prog = 3'd0;
					end else begin
						nxt.fail_prog = cur.fail_prog + 3'd1;
					end
				end else begin
					nxt.fail_prog = (rx_byte == CH_F) ? 3'd1 : 3'd0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/atrp_core.sv -----
`default_nettype none
module atrp_core import atrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        fire,
	input  atrp_req_t   req,
	output atrp_push_t  push
);

	logic             waiting_q, waiting_n;
	logic [31:0]      elapsed_q, elapsed_n;
	logic [31:0]      active_tmo_q, active_tmo_n;
	logic [31:0]      default_tmo_q;
	logic [CNT_W-1:0] line_cnt_q, line_cnt_n;
	logic [31:0]      raw_left_q, raw_left_n;
	atrp_match_t      match_q, match_n, match_upd;

	logic             do_end;
	logic [CNT_W-1:0] cnt_inc;
	logic [31:0]      el_inc;
	logic [1:0]       n;
	atrp_res_t        r0, r1;

	atrp_matcher u_matcher (
		.cur     (match_q),
		.rx_byte (req.rx_byte),
		.nxt     (match_upd)
	);

	function automatic atrp_res_t mk_res(input logic [2:0] ev, input logic [7:0] d,
			input logic [LEN_W-1:0] len);
		atrp_res_t r;
		r.event_res   = ev;
		r.data_byte   = d;
		r.line_length = len;
		r.last        = 1'b0;
		return r;
	endfunction

	assign cnt_inc = line_cnt_q + CNT_W'(1);
	assign el_inc  = (elapsed_q == 32'hFFFF_FFFF) ? elapsed_q : elapsed_q + 32'd1;

	always_comb begin
		waiting_n    = waiting_q;
		elapsed_n    = elapsed_q;
		active_tmo_n = active_tmo_q;
		line_cnt_n   = line_cnt_q;
		raw_left_n   = raw_left_q;
		match_n      = match_q;
		do_end       = 1'b0;
		n            = 2'd0;
		r0           = mk_res(EV_RAW, 8'd0, '0);
		r1           = mk_res(EV_RAW, 8'd0, '0);
		case (req.kind)
			KIND_BYTE: begin
				if (raw_left_q != 32'd0) begin
					raw_left_n = raw_left_q - 32'd1;
					n          = 2'd1;
					r0         = mk_res(EV_RAW, req.rx_byte, '0);
				end else if (req.rx_byte inside {CH_CR, CH_LF, CH_GT}) begin
					if (req.rx_byte == CH_GT) begin
						match_n    = match_upd;
						line_cnt_n = cnt_inc;
					end
					if (line_cnt_n != '0) begin
						do_end = 1'b1;
					end
				end else if (line_cnt_q < CNT_W'(LINE_LIMIT - 1)) begin
					match_n    = match_upd;
					line_cnt_n = cnt_inc;
				end else begin
					do_end = 1'b1;
				end
			end
			KIND_CMD: begin
				n = 2'd1;
				if (waiting_q) begin
					r0 = mk_res(EV_REJECT, 8'd0, '0);
				end else begin
					waiting_n    = 1'b1;
					elapsed_n    = 32'd0;
					active_tmo_n = (req.timeout_ms != 32'd0) ? req.timeout_ms : default_tmo_q;
					line_cnt_n   = '0;
					match_n      = MATCH_CLEAR;
					r0           = mk_res(EV_ACCEPT, 8'd0, '0);
				end
			end
			KIND_TICK: begin
				if (waiting_q) begin
					elapsed_n = el_inc;
					if (el_inc > active_tmo_q) begin
						waiting_n = 1'b0;
						n         = 2'd1;
						r0        = mk_res(EV_TIMEOUT, 8'd0, '0);
					end
				end
			end
			KIND_RAW: begin
				raw_left_n = req.raw_length;
			end
			default: begin
			end
		endcase

		if (do_end) begin
			r0 = mk_res(EV_LINE, 8'd0, LEN_W'(line_cnt_n));
			n  = 2'd1;
			if (waiting_q && match_n.found != 2'b00) begin
				r1        = mk_res(match_n.found[0] ? EV_OK : EV_ERROR, 8'd0,
					LEN_W'(line_cnt_n));
				n         = 2'd2;
				waiting_n = 1'b0;
			end
			line_cnt_n = '0;
			match_n    = MATCH_CLEAR;
		end

		r0.last = (n == 2'd1);
		r1.last = 1'b1;

		push.n  = fire ? n : 2'd0;
		push.r0 = r0;
		push.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q     <= 1'b0;
			elapsed_q     <= 32'd0;
			active_tmo_q  <= 32'd0;
			line_cnt_q    <= '0;
			raw_left_q    <= 32'd0;
			match_q       <= MATCH_CLEAR;
			default_tmo_q <= DEFAULT_TIMEOUT_RST;
		end else begin
			if (cfg_wr_en) begin
				default_tmo_q <= cfg_wr_data;
			end
			if (fire) begin
				waiting_q    <= waiting_n;
				elapsed_q    <= elapsed_n;
				active_tmo_q <= active_tmo_n;
				line_cnt_q   <= line_cnt_n;
				raw_left_q   <= raw_left_n;
				match_q      <= match_n;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/atrp_res_fifo.sv -----
`default_nettype none
module atrp_res_fifo import atrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  atrp_push_t push,
	output logic       room,
	atrp_out_if.source rsp
);

	atrp_res_t         mem [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	logic              pop;
	atrp_res_t         head;

	assign pop  = rsp.valid && rsp.ready;
	assign room = (count_q <= FCNT_W'(FIFO_DEPTH - 2));
	assign head = mem[rd_ptr_q];

	assign rsp.valid       = (count_q != '0);
	assign rsp.event_res   = head.event_res;
	assign rsp.data_byte   = head.data_byte;
	assign rsp.line_length = head.line_length;
	assign rsp.last        = head.last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + FCNT_W'(push.n) - FCNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// ----- tb/atrp_response_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module atrp_response_checker import atrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	atrp_in_if          req,
	atrp_out_if         rsp,
	output int          mismatches,
	output int          awaited,
	output int          results_seen
);

	localparam logic [39:0] ERROR_WORD = {CH_E, CH_R, CH_R, CH_O, CH_R};
	localparam logic [31:0] FAIL_WORD  = {CH_F, CH_A, CH_I, CH_L};

	// parser state as seen from outside
	logic [31:0] default_limit;
	logic        waiting;
	logic [31:0] elapsed;
	logic [31:0] limit;
	logic [31:0] raw_left;
	logic [8:0]  line_len;
	logic        ok_step;
	int          err_step;
	int          fail_step;
	logic        found_ok;
	logic        found_err;
	logic        zero_seen;

	atrp_res_t awaited_events[$];
	atrp_res_t staged[2];
	int        staged_n;

	task automatic report(input string msg);
		if (mismatches < 40) $display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic stage(input logic [2:0] ev, input logic [7:0] data, input logic [8:0] len);
		staged[staged_n] = {ev, data, len, 1'b0};
		staged_n++;
	endtask

	task automatic restart_line();
		line_len = '0;
		ok_step = 1'b0;
		err_step = 0;
		fail_step = 0;
		found_ok = 1'b0;
		found_err = 1'b0;
		zero_seen = 1'b0;
	endtask

	task automatic scan_char(input logic [7:0] c);
		if (zero_seen) return;
		if (c == CH_NUL) begin
			zero_seen = 1'b1;
			return;
		end
		if (ok_step && c == CH_K) begin
			found_ok = 1'b1;
			ok_step = 1'b0;
		end else begin
			ok_step = (c == CH_O);
		end
		if (c == ERROR_WORD[39 - 8 * err_step -: 8]) begin
			err_step++;
			if (err_step == 5) begin
				found_err = 1'b1;
				err_step = 0;
			end
		end else begin
			err_step = (c == CH_E) ? 1 : 0;
		end
		if (c == FAIL_WORD[31 - 8 * fail_step -: 8]) begin
			fail_step++;
			if (fail_step == 4) begin
				found_err = 1'b1;
				fail_step = 0;
			end
		end else begin
			fail_step = (c == CH_F) ? 1 : 0;
		end
	endtask

	task automatic close_line();
		stage(EV_LINE, '0, line_len);
		if (waiting && (found_ok || found_err)) begin
			stage(found_ok ? EV_OK : EV_ERROR, '0, line_len);
			waiting = 1'b0;
		end
		restart_line();
	endtask

	task automatic parse_item(input logic [1:0] kind, input logic [7:0] c,
			input logic [31:0] tmo, input logic [31:0] rlen);
		staged_n = 0;
		case (kind)
			KIND_BYTE: begin
				if (raw_left != 0) begin
					raw_left--;
					stage(EV_RAW, c, '0);
				end else if (c == CH_CR || c == CH_LF || c == CH_GT) begin
					if (c == CH_GT) begin
						scan_char(c);
						line_len++;
					end
					if (line_len != 0) close_line();
				end else if (line_len < LINE_LIMIT - 1) begin
					scan_char(c);
					line_len++;
				end else begin
					// byte past the limit: line cut, byte lost
					close_line();
				end
			end
			KIND_CMD: begin
				if (waiting) begin
					stage(EV_REJECT, '0, '0);
				end else begin
					waiting = 1'b1;
					elapsed = '0;
					limit = (tmo != 0) ? tmo : default_limit;
					restart_line();
					stage(EV_ACCEPT, '0, '0);
				end
			end
			KIND_TICK: begin
				if (waiting) begin
					if (elapsed != '1) elapsed++;
					if (elapsed > limit) begin
						waiting = 1'b0;
						stage(EV_TIMEOUT, '0, '0);
					end
				end
			end
			KIND_RAW: raw_left = rlen;
		endcase
		if (staged_n > 0) staged[staged_n - 1].last = 1'b1;
		for (int i = 0; i < staged_n; i++) awaited_events.push_back(staged[i]);
	endtask

	task automatic check_result();
		atrp_res_t want;
		results_seen++;
		if (awaited_events.size() == 0) begin
			report($sformatf("result %0d (event %0d) with nothing awaited",
				results_seen, rsp.event_res));
			return;
		end
		want = awaited_events.pop_front();
		if (rsp.event_res != want.event_res)
			report($sformatf("result %0d event: expected %0d, got %0d",
				results_seen, want.event_res, rsp.event_res));
		if (rsp.data_byte != want.data_byte)
			report($sformatf("result %0d data byte: expected %0d, got %0d",
				results_seen, want.data_byte, rsp.data_byte));
		if (rsp.line_length != want.line_length)
			report($sformatf("result %0d line length: expected %0d, got %0d",
				results_seen, want.line_length, rsp.line_length));
		if (rsp.last != want.last)
			report($sformatf("result %0d last: expected %0d, got %0d",
				results_seen, want.last, rsp.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_limit = DEFAULT_TIMEOUT_RST;
			waiting = 1'b0;
			elapsed = '0;
			limit = '0;
			raw_left = '0;
			restart_line();
			awaited_events.delete();
			mismatches = 0;
			results_seen = 0;
		end else begin
			// results first: nothing accepted at this edge can already be out
			if (rsp.valid && rsp.ready) check_result();
			if (cfg_wr_en) default_limit = cfg_wr_data;
			if (req.valid && req.ready)
				parse_item(req.kind, req.rx_byte, req.timeout_ms, req.raw_length);
		end
		awaited <= awaited_events.size();
	end

endmodule
`default_nettype wire

// ----- tb/at_response_line_parser_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module at_response_line_parser_test;
	import atrp_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int SETTLE_CYCLES    = 6;
	localparam int SINK_HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS     = 150;
	localparam int PHASES           = 5;

	// how a line of full length is finished
	typedef enum int {END_PROMPT, END_CUT, END_PLAIN} line_ending_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	atrp_in_if  req_ch();
	atrp_out_if rsp_ch();

	int          mismatches;
	int          awaited;
	int          results_seen;
	int          cycle_count = 0;
	int          hold_requests = 0;
	int          burst_left = 0;
	bit          no_gaps = 1'b0;
	int          items_sent = 0;
	int          kind_totals[4] = '{0, 0, 0, 0};
	int          settings_done = 0;
	logic [31:0] default_now = DEFAULT_TIMEOUT_RST;

	at_response_line_parser DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	atrp_response_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.mismatches   (mismatches),
		.awaited      (awaited),
		.results_seen (results_seen)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog: a hung handshake or a lost result ends up here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL at_response_line_parser");
			$finish;
		end
	end

	// result side: stall patterns of its own, plus a long hold-off on request
	initial begin : result_sink
		int mode, span_left, hold_left, holds_served, phase;
		mode = 0;
		span_left = 0;
		hold_left = 0;
		holds_served = 0;
		phase = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = SINK_HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (span_left == 0) begin
					mode = $urandom_range(0, 3);
					span_left = $urandom_range(4, 48);
				end
				span_left--;
				phase++;
				case (mode)
					0:       rsp_ch.ready <= 1'b1;                 // no stalls at all
					1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
					2:       rsp_ch.ready <= (phase % 4 == 0);     // heavy back-pressure
					default: rsp_ch.ready <= phase[0];
				endcase
			end
		end
	end

	// offers one item, in bursts with random gaps between them
	task automatic send_item(input logic [1:0] kind, input logic [7:0] b,
			input logic [31:0] tmo, input logic [31:0] rlen);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= kind;
		req_ch.rx_byte    <= b;
		req_ch.timeout_ms <= tmo;
		req_ch.raw_length <= rlen;
		do @(posedge clk); while (!req_ch.ready);
		if (burst_left > 0) burst_left--;
		items_sent++;
		kind_totals[kind]++;
	endtask

	// unused fields carry random values so that every bit moves
	task automatic send_byte(input logic [7:0] b);
		send_item(KIND_BYTE, b, $urandom(), $urandom());
	endtask

	task automatic send_cmd(input logic [31:0] tmo);
		send_item(KIND_CMD, 8'($urandom_range(0, 255)), tmo, $urandom());
	endtask

	task automatic send_tick();
		send_item(KIND_TICK, 8'($urandom_range(0, 255)), $urandom(), $urandom());
	endtask

	task automatic send_raw(input logic [31:0] len);
		send_item(KIND_RAW, 8'($urandom_range(0, 255)), $urandom(), len);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// printable text, leaning on the letters of the reply words, never a line end
	function automatic logic [7:0] text_char();
		string letters = "OKERFAIL";
		logic [7:0] c;
		if ($urandom_range(0, 2) == 0) c = letters[$urandom_range(0, letters.len() - 1)];
		else c = 8'($urandom_range(8'h20, 8'h7E));
		if (c == CH_GT) c = CH_O;
		return c;
	endfunction

	function automatic logic [7:0] line_end();
		case ($urandom_range(0, 2))
			0:       return CH_CR;
			1:       return CH_LF;
			default: return CH_GT;
		endcase
	endfunction

	task automatic send_filler(input int n);
		repeat (n) send_byte(text_char());
	endtask

	// a line brought right up to the length limit, then finished one of three ways
	task automatic long_line(input line_ending_t ending);
		int lead;
		lead = 0;
		send_raw(0);
		send_byte(CH_LF);
		if ($urandom_range(0, 1)) send_cmd(0);
		case ($urandom_range(0, 2))
			0: begin
				send_text("OK");
				lead = 2;
			end
			1: begin
				send_text("ERROR");
				lead = 5;
			end
			default: ;
		endcase
		send_filler(LINE_LIMIT - 1 - lead);
		case (ending)
			END_PROMPT: send_byte(CH_GT);
			END_CUT: begin
				send_byte(text_char());
				send_byte(line_end());
			end
			default: send_byte(CH_CR);
		endcase
	endtask

	// one random stretch of traffic, mostly well-formed command exchanges
	task automatic run_sequence();
		string broken[8] = '{"ERRO", "FAI", "O K", "OERROK", "EERROR", "FFAIL",
			"ERRFAIL", "KO"};
		logic [31:0] tmo, limit_now;
		int pick, n;
		pick = $urandom_range(0, 15);
		if (pick <= 6) begin
			// command, a few lines, maybe ticks, then a reply line
			case ($urandom_range(0, 4))
				0:       tmo = '0;
				1, 2:    tmo = $urandom_range(1, 12);
				3:       tmo = $urandom();
				default: tmo = '1;
			endcase
			send_cmd(tmo);
			limit_now = (tmo != 0) ? tmo : default_now;
			if ($urandom_range(0, 4) == 0) send_cmd($urandom());
			n = $urandom_range(0, 2);
			repeat (n) begin
				send_filler($urandom_range(0, 6));
				send_byte(line_end());
			end
			if (limit_now <= 16 && $urandom_range(0, 1) == 0)
				repeat ($urandom_range(0, limit_now + 2)) send_tick();
			else if ($urandom_range(0, 3) == 0)
				send_tick();
			send_filler($urandom_range(0, 5));
			case ($urandom_range(0, 4))
				0: send_text("OK");
				1: send_text("ERROR");
				2: send_text("FAIL");
				3: begin
					// both found on one line: ok wins
					send_text("ERROR");
					send_filler(n);
					send_text("OK");
				end
				default: ;
			endcase
			send_filler($urandom_range(0, 4));
			send_byte(line_end());
		end else if (pick <= 8) begin
			send_raw($urandom_range(0, 6));
			repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 255)));
		end else if (pick == 9) begin
			// huge raw count, cancelled again
			send_raw($urandom());
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
			send_raw(0);
		end else if (pick <= 11) begin
			// near misses and embedded matches, and a zero byte that blinds the matcher
			if ($urandom_range(0, 1)) send_cmd($urandom_range(0, 40));
			send_filler($urandom_range(0, 3));
			if ($urandom_range(0, 2) == 0) send_byte(CH_NUL);
			send_text(broken[$urandom_range(0, 7)]);
			send_filler($urandom_range(0, 3));
			send_byte(line_end());
		end else if (pick == 12) begin
			repeat ($urandom_range(1, 10))
				send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					$urandom(), $urandom_range(0, 3));
		end else if (pick == 13) begin
			repeat ($urandom_range(1, 6)) send_tick();
		end else if (pick == 15 && $urandom_range(0, 5) == 0) begin
			long_line(line_ending_t'($urandom_range(0, 2)));
		end else begin
			// empty line ends and lone prompts
			repeat ($urandom_range(1, 3)) send_byte(line_end());
		end
	endtask

	// stop offering and wait until every awaited result is in
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		// items with no result may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_default(input logic [31:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		default_now = value;
		settings_done++;
	endtask

	initial begin : stimulus
		logic [31:0] phase_defaults[PHASES];
		int p, start;
		phase_defaults = '{32'd0, 32'd3, 32'hFFFF_FFFF, $urandom(), DEFAULT_TIMEOUT_RST};
		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_wr_data       <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.kind       <= KIND_BYTE;
		req_ch.rx_byte    <= '0;
		req_ch.timeout_ms <= '0;
		req_ch.raw_length <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset default timeout of 1000 ms
		send_byte(CH_CR);              // empty line, nothing comes out
		send_byte(CH_GT);              // prompt on its own is a line of one
		send_tick();                   // tick while idle is ignored
		send_cmd(0);                   // accepted, default limit
		send_cmd('1);                  // rejected while waiting
		send_text("OK");
		send_byte(CH_CR);              // line then ok
		send_cmd(1);
		send_tick();
		send_tick();                   // elapsed passes the limit: timeout
		send_cmd('1);
		send_byte(CH_NUL);
		send_text("OK");
		send_byte(CH_LF);              // ok hidden behind a zero byte
		send_text("FAIL");
		send_byte(CH_LF);              // error ends the wait
		send_raw(2);
		send_byte(8'hFF);
		send_byte(CH_NUL);             // both forwarded untouched
		send_raw('1);
		send_raw(0);

		// random part over several default timeout settings
		for (p = 0; p < PHASES; p++) begin
			drain_results();
			write_default(phase_defaults[p]);
			if (p == 0) begin
				long_line(END_PROMPT);
				long_line(END_CUT);
			end
			if (p == 2) begin
				// receiver holds off while commands keep coming, so the block backs up
				hold_requests <= hold_requests + 1;
				no_gaps = 1'b1;
				repeat (30) send_cmd($urandom());
				no_gaps = 1'b0;
				send_raw(0);
				send_byte(CH_LF);
				send_text("OK");
				send_byte(CH_CR);
				drain_results();
			end
			start = items_sent;
			while (items_sent - start < RANDOM_ITEMS / PHASES) run_sequence();
		end
		drain_results();

		$display("covered %0d items: %0d bytes, %0d commands, %0d ticks, %0d raw requests",
			items_sent, kind_totals[KIND_BYTE], kind_totals[KIND_CMD],
			kind_totals[KIND_TICK], kind_totals[KIND_RAW]);
		$display("%0d results checked over %0d default timeout settings, with cut lines",
			results_seen, settings_done);
		if (mismatches == 0) begin
			$display("PASS at_response_line_parser");
		end else begin
			$display("FAIL at_response_line_parser");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/atrp_pkg.sv
rtl/atrp_if.sv
rtl/atrp_matcher.sv
rtl/atrp_core.sv
rtl/atrp_res_fifo.sv
rtl/at_response_line_parser.sv
tb/atrp_response_checker.sv
tb/at_response_line_parser_test.sv
